// File: rtl/core/xpm_pkg.sv
// ----------------------------------------------------------------------------
// xpm_pkg: shared types and constants for the x power mod recurrence block
// Word widths, register indexes and the cell control bundle.
// ----------------------------------------------------------------------------
package xpm_pkg;

    localparam int unsigned WORD_W = 32;   // coefficient word
    localparam int unsigned EXP_W  = 63;   // exponent
    localparam int unsigned SLOT_W = 4;    // coefficient slot
    localparam int unsigned DEG_W  = 5;    // relation degree register
    localparam int unsigned TIDX_W = 4;    // term index field

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [WORD_W+1:0] wide_t;     // holds up to 4p

    // configuration register indexes
    localparam logic REG_PRIME  = 1'b0;
    localparam logic REG_DEGREE = 1'b1;

    localparam word_t PRIME_RESET  = 32'd1000000007;
    localparam logic [DEG_W-1:0] DEGREE_RESET = 5'd2;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic init;     // load x^0 into accum, x^1 into square
        logic clr_r;    // clear the Horner accumulator
        logic load;     // start one scalar step: latch multiplier bits
        logic step;     // one bit of the interleaved modular multiply
        logic fold;     // shift the accumulator up one cell and add
        logic wr_a;     // accum <= result
        logic wr_s;     // square <= result
    } cell_ctrl_t;

endpackage

// File: rtl/core/xpm_cell.sv
// ----------------------------------------------------------------------------
// xpm_cell: one coefficient slot of the polynomial chain
// Holds a_i, accum_i, square_i and the Horner accumulator r_i, and runs a
// bit-serial c*a_i + x*square_i mod p, then takes r_(i-1) from its neighbor.
// ----------------------------------------------------------------------------
module xpm_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  xpm_pkg::cell_ctrl_t   ctrl,
    input  xpm_pkg::word_t        p,
    input  xpm_pkg::wide_t        p2,
    input  xpm_pkg::wide_t        p3,
    input  xpm_pkg::word_t        one,
    input  xpm_pkg::word_t        c,        // top coefficient of r, broadcast
    input  xpm_pkg::word_t        x,        // current multiplicand coefficient
    input  xpm_pkg::word_t        r_prev,   // r of the cell below
    input  logic                  tbl_we,
    input  xpm_pkg::word_t        tbl_data,
    output xpm_pkg::word_t        a_val,
    output xpm_pkg::word_t        s_val,
    output xpm_pkg::word_t        r_val
);
    import xpm_pkg::*;

    word_t t_reg, t_next;
    word_t a_reg, a_next;
    word_t s_reg, s_next;
    word_t r_reg, r_next;
    word_t acc_reg, acc_next;
    word_t ts_reg, ts_next;
    word_t ys_reg, ys_next;

    wide_t v;
    logic [WORD_W:0] sum;

    always_comb begin
        v = {acc_reg, 1'b0}
            + (ts_reg[WORD_W-1] ? {2'b00, c} : '0)
            + (ys_reg[WORD_W-1] ? {2'b00, x} : '0);
        sum = {1'b0, r_prev} + {1'b0, acc_reg};

        t_next   = tbl_we ? tbl_data : t_reg;
        a_next   = a_reg;
        s_next   = s_reg;
        r_next   = r_reg;
        acc_next = acc_reg;
        ts_next  = ts_reg;
        ys_next  = ys_reg;

        if (ctrl.init) begin
            a_next = (IDX == 0) ? one : '0;
            s_next = (IDX == 1) ? one : '0;
        end
        if (ctrl.wr_a) a_next = r_reg;
        if (ctrl.wr_s) s_next = r_reg;
        if (ctrl.clr_r) r_next = '0;
        if (ctrl.load) begin
            acc_next = '0;
            ts_next  = t_reg;
            ys_next  = s_reg;
        end
        if (ctrl.step) begin
            // v < 4p, take off the largest multiple of p that fits
            if (v >= p3)                    acc_next = WORD_W'(v - p3);
            else if (v >= p2)               acc_next = WORD_W'(v - p2);
            else if (v >= {2'b00, p})       acc_next = WORD_W'(v - {2'b00, p});
            else                            acc_next = WORD_W'(v);
            ts_next = {ts_reg[WORD_W-2:0], 1'b0};
            ys_next = {ys_reg[WORD_W-2:0], 1'b0};
        end
        if (ctrl.fold) begin
            r_next = (sum >= {1'b0, p}) ? WORD_W'(sum - {1'b0, p}) : WORD_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg <= '0;
        end else begin
            t_reg <= t_next;
        end
        a_reg   <= a_next;
        s_reg   <= s_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
        ts_reg  <= ts_next;
        ys_reg  <= ys_next;
    end

    assign a_val = a_reg;
    assign s_val = s_reg;
    assign r_val = r_reg;

endmodule

// File: rtl/core/xpm_seq.sv
// ----------------------------------------------------------------------------
// xpm_seq: sequencer for the cell chain
// Walks the exponent bits, the Horner steps and the multiplier bits, then
// reads the result out one coefficient per request.
// ----------------------------------------------------------------------------
module xpm_seq #(
    parameter int unsigned MAX_DEGREE = 16,
    parameter int unsigned IW = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [xpm_pkg::EXP_W-1:0]    exponent,
    input  logic [xpm_pkg::DEG_W-1:0]    degree,
    input  logic                         out_free,
    output xpm_pkg::cell_ctrl_t          ctrl,
    output logic                         idle,
    output logic                         x_from_acc,
    output logic [IW-1:0]                j_idx,
    output logic [IW-1:0]                n_last,
    output logic                         out_load,
    output logic [IW-1:0]                out_idx,
    output logic                         out_last
);
    import xpm_pkg::*;

    localparam int unsigned BW = $clog2(WORD_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_BIT  = 3'd3;
    localparam logic [2:0] S_FOLD = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [EXP_W-1:0] e_reg, e_next;
    logic [IW-1:0]    nlast_reg, nlast_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [BW-1:0]    bit_reg, bit_next;
    logic             accm_reg, accm_next;
    logic [IW-1:0]    oidx_reg, oidx_next;
    logic [IW-1:0]    nlast_clamp;

    always_comb begin
        if (int'(degree) < 2)               nlast_clamp = IW'(1);
        else if (int'(degree) > MAX_DEGREE) nlast_clamp = IW'(MAX_DEGREE - 1);
        else                                nlast_clamp = IW'(int'(degree) - 1);
    end

    always_comb begin
        state_next = state_reg;
        e_next     = e_reg;
        nlast_next = nlast_reg;
        j_next     = j_reg;
        bit_next   = bit_reg;
        accm_next  = accm_reg;
        oidx_next  = oidx_reg;
        ctrl       = '0;
        out_load   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    ctrl.init  = 1'b1;
                    e_next     = exponent;
                    nlast_next = nlast_clamp;
                    oidx_next  = '0;
                    state_next = (exponent == '0) ? S_OUT : S_PREP;
                end
            end
            S_PREP: begin
                ctrl.clr_r = 1'b1;
                accm_next  = e_reg[0];
                j_next     = nlast_reg;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                ctrl.load  = 1'b1;
                bit_next   = BW'(WORD_W - 1);
                state_next = S_BIT;
            end
            S_BIT: begin
                ctrl.step = 1'b1;
                if (bit_reg == '0) state_next = S_FOLD;
                else               bit_next = bit_reg - 1'b1;
            end
            S_FOLD: begin
                ctrl.fold = 1'b1;
                if (j_reg == '0) begin
                    state_next = S_WB;
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_WB: begin
                if (accm_reg) begin
                    ctrl.wr_a = 1'b1;
                    if (e_reg[EXP_W-1:1] == '0) begin
                        oidx_next  = '0;
                        state_next = S_OUT;
                    end else begin
                        ctrl.clr_r = 1'b1;
                        accm_next  = 1'b0;
                        j_next     = nlast_reg;
                        state_next = S_LOAD;
                    end
                end else begin
                    // remaining exponent is nonzero whenever a square ran
                    ctrl.wr_s  = 1'b1;
                    e_next     = e_reg >> 1;
                    state_next = S_PREP;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (oidx_reg == nlast_reg) state_next = S_IDLE;
                    else                       oidx_next = oidx_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        e_reg     <= e_next;
        nlast_reg <= nlast_next;
        j_reg     <= j_next;
        bit_reg   <= bit_next;
        accm_reg  <= accm_next;
        oidx_reg  <= oidx_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign x_from_acc = accm_reg;
    assign j_idx      = j_reg;
    assign n_last     = nlast_reg;
    assign out_idx    = oidx_reg;
    assign out_last   = (oidx_reg == nlast_reg);

endmodule

// File: rtl/core/x_power_mod_recurrence_poly.sv
// ----------------------------------------------------------------------------
// x_power_mod_recurrence_poly: x^k modulo a linear recurrence relation, mod p
// Square-and-multiply over a chain of coefficient cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one request per item. tuser = cmd. A load (cmd 0)
//   writes coef_word into table slot coef_slot in the accept cycle and
//   returns nothing. A compute (cmd 1) raises x to exponent and returns n
//   requests on m_*, lowest power first, tlast on index n-1.
//   Config port: cfg_wr_en/cfg_addr/cfg_wr_data, index 0 = prime p,
//   index 1 = degree n. Write only while the block is idle.
// Schedule:
//   One polynomial product is n Horner steps on the cell chain, each a
//   load, a bit-serial multiply over the WORD_W multiplier bits and a
//   fold. A compute costs one product per exponent bit below the top one
//   plus one per set bit, then the n results are sent. One item at a
//   time; s_tready is high only while idle.
// Reset: table cleared to zeros, p = 1000000007, n = 2, stream idle.
// Stall: results sit in the output register until m_tready; the sequencer
//   waits, nothing is lost. A new request is taken while the last result
//   is still waiting.
// ----------------------------------------------------------------------------
module x_power_mod_recurrence_poly #(
    parameter int unsigned MAX_DEGREE = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // coef_slot[3:0], coef_word[35:4], exponent[98:36]
    input  logic [0:0]    s_tuser,   // cmd[0]
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,   // term_index[3:0], term_value[35:4]
    output logic          m_tlast,   // final_term
    // configuration
    input  logic          cfg_wr_en,
    input  logic          cfg_addr,
    input  logic [31:0]   cfg_wr_data
);
    import xpm_pkg::*;

    localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    // input field unpack
    logic                  in_cmd;
    logic [SLOT_W-1:0]     in_slot;
    word_t                 in_word;
    logic [EXP_W-1:0]      in_exp;
    logic                  accept;

    assign in_cmd  = s_tuser[0];
    assign in_slot = s_tdata[3:0];
    assign in_word = s_tdata[35:4];
    assign in_exp  = s_tdata[98:36];
    assign accept  = s_tvalid && s_tready;

    // configuration: p kept with its 2p and 3p for the cell reductions
    word_t               p_reg, p_next;
    wide_t               p2_reg, p2_next;
    wide_t               p3_reg, p3_next;
    logic [DEG_W-1:0]    deg_reg, deg_next;
    word_t               p_wr;

    always_comb begin
        p_wr     = (cfg_wr_data == '0) ? word_t'(1) : cfg_wr_data;  // zero acts as one
        p_next   = p_reg;
        p2_next  = p2_reg;
        p3_next  = p3_reg;
        deg_next = deg_reg;
        if (cfg_wr_en) begin
            if (cfg_addr == REG_PRIME) begin
                p_next  = p_wr;
                p2_next = {1'b0, p_wr, 1'b0};
                p3_next = {2'b00, p_wr} + {1'b0, p_wr, 1'b0};
            end else if (cfg_addr == REG_DEGREE) begin
                deg_next = cfg_wr_data[DEG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg   <= PRIME_RESET;
            p2_reg  <= {1'b0, PRIME_RESET, 1'b0};
            p3_reg  <= {2'b00, PRIME_RESET} + {1'b0, PRIME_RESET, 1'b0};
            deg_reg <= DEGREE_RESET;
        end else begin
            p_reg   <= p_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            deg_reg <= deg_next;
        end
    end

    // constant one of the ring; zero when p is one
    word_t one;
    assign one = (p_reg == word_t'(1)) ? '0 : word_t'(1);

    // sequencer
    cell_ctrl_t     ctrl;
    logic           idle;
    logic           x_from_acc;
    logic [IW-1:0]  j_idx;
    logic [IW-1:0]  n_last;
    logic           out_load;
    logic [IW-1:0]  out_idx;
    logic           out_last;
    logic           out_free;

    assign out_free = !m_tvalid || m_tready;
    assign s_tready = idle;

    xpm_seq #(
        .MAX_DEGREE (MAX_DEGREE),
        .IW         (IW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept && in_cmd),
        .exponent   (in_exp),
        .degree     (deg_reg),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .idle       (idle),
        .x_from_acc (x_from_acc),
        .j_idx      (j_idx),
        .n_last     (n_last),
        .out_load   (out_load),
        .out_idx    (out_idx),
        .out_last   (out_last)
    );

    // cell chain: r moves up one cell per fold, the top coefficient of r
    // and the current multiplicand coefficient are broadcast
    word_t a_arr [MAX_DEGREE];
    word_t s_arr [MAX_DEGREE];
    word_t r_arr [MAX_DEGREE];
    word_t c_bcast;
    word_t x_bcast;

    assign c_bcast = r_arr[n_last];
    assign x_bcast = x_from_acc ? a_arr[j_idx] : s_arr[j_idx];

    for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
        word_t r_below;
        logic  we;
        if (i == 0) begin : g_bottom
            assign r_below = '0;
        end else begin : g_mid
            assign r_below = r_arr[i-1];
        end
        assign we = accept && !in_cmd && (int'(in_slot) == i);

        xpm_cell #(
            .IDX (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .p        (p_reg),
            .p2       (p2_reg),
            .p3       (p3_reg),
            .one      (one),
            .c        (c_bcast),
            .x        (x_bcast),
            .r_prev   (r_below),
            .tbl_we   (we),
            .tbl_data (in_word),
            .a_val    (a_arr[i]),
            .s_val    (s_arr[i]),
            .r_val    (r_arr[i])
        );
    end

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [39:0]   m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0000, a_arr[out_idx], TIDX_W'(out_idx)};
            m_last_next  = out_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
